[rtl/ssdd_pkg.sv]
// Shared types, codes and constants for the stereo sound direction detector.
package ssdd_pkg;

    // Field and register widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned ENERGY_W   = 48;
    localparam int unsigned COOLDOWN_W = 24;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned CFG_W      = 48;
    localparam int unsigned BAL_W      = 16;

    // Serial multiplier: 16-bit multiplier consumed two bits per cycle
    localparam int unsigned MUL_B_W     = 16;
    localparam int unsigned MUL_DIGIT_W = 2;
    localparam int unsigned MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
    localparam int unsigned MUL_CNT_W   = $clog2(MUL_STEPS);

    // Balance divider: one quotient bit per cycle
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Largest positive balance, Q1.15
    localparam logic [BAL_W-1:0] BAL_POS_MAX = 16'h7FFF;

    // Register reset values
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET   = 24'd500000;
    localparam logic [ENERGY_W-1:0]   ENERGY_THR_RESET = 48'd1000000;
    localparam logic [COEF_W-1:0]     BAL_THR_RESET    = 16'd19661;
    localparam logic [COEF_W-1:0]     ALPHA_RESET      = 16'd58600;

    // Configuration register indexes
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_COOLDOWN    = 2'd0;
    localparam reg_index_t REG_ENERGY_THR  = 2'd1;
    localparam reg_index_t REG_BALANCE_THR = 2'd2;
    localparam reg_index_t REG_HP_ALPHA    = 2'd3;

    // Direction codes
    typedef enum logic [1:0] {
        DIR_LEFT   = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_CENTRE = 2'd2
    } dir_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_MUL_ALPHA,
        ST_MUL_SQ,
        ST_DEC_SUM,
        ST_DEC_GATE,
        ST_DEC_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

[rtl/ssdd_smul.sv]
// Digit-serial unsigned multiplier, two multiplier bits per cycle.
module ssdd_smul #(
    parameter int A_W = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [A_W-1:0]                       a,
    input  logic [ssdd_pkg::MUL_B_W-1:0]         b,
    output logic                                 done,
    output logic [A_W+ssdd_pkg::MUL_B_W-1:0]     product
);

    logic [A_W-1:0]                     a_reg;
    logic [ssdd_pkg::MUL_B_W-1:0]       lo_reg;
    logic [A_W:0]                       acc_reg;
    logic [ssdd_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [A_W+1:0]                     a_x3;
    logic [A_W+1:0]                     pp;
    logic [A_W+2:0]                     sum;
    logic                               last_step;

    // Form the partial product for the low digit and add it to the high half
    always_comb
    begin
        a_x3 = {2'b00, a_reg} + {1'b0, a_reg, 1'b0};
        case (lo_reg[ssdd_pkg::MUL_DIGIT_W-1:0])
            2'd0:    pp = '0;
            2'd1:    pp = {2'b00, a_reg};
            2'd2:    pp = {1'b0, a_reg, 1'b0};
            2'd3:    pp = a_x3;
            default: pp = '0;
        endcase
        sum = {2'b00, acc_reg} + {1'b0, pp};
        last_step = (cnt_reg == ssdd_pkg::MUL_CNT_W'(ssdd_pkg::MUL_STEPS - 1));
    end

    // Track the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Load operands, then shift the product down one digit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            lo_reg  <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[A_W+2:ssdd_pkg::MUL_DIGIT_W];
            lo_reg  <= {sum[ssdd_pkg::MUL_DIGIT_W-1:0],
                        lo_reg[ssdd_pkg::MUL_B_W-1:ssdd_pkg::MUL_DIGIT_W]};
        end
    end

    assign done    = done_reg;
    assign product = {acc_reg[A_W-1:0], lo_reg};

endmodule

[rtl/stereo_sound_direction_detector.sv]
// Top level of the stereo sound direction detector.
//
// Usage: stereo sample pairs enter on the in_valid/in_ready channel, marked
// with first_of_frame and last_of_frame. A request on the first pair of a
// frame is checked against the cooldown from the last emitted event; a frame
// inside the cooldown is dropped whole, though its pairs are taken. Each
// other pair runs both high-pass filters and energy squares on two
// digit-serial multipliers (two bits per cycle): the alpha multiply and then
// the square, 8 steps each. On the last pair the frame is decided: sum,
// silence gate, balance-threshold multiply (8 steps) and a bit-serial
// divider (16 steps) for the balance. A direction request goes out on
// out_valid/out_ready only when the direction changes. The output register
// holds one result, so the next pair is taken while it waits; if the
// receiver stalls and a new result is ready, the block holds in its emit
// step until the register frees.
// Reset (rst_n low, asynchronous) restores the default registers, clears
// filter state and sums, sets the last direction to centre and the last
// emit time to zero. The configuration port writes one register per cycle.
module stereo_sound_direction_detector #(
    parameter int FILTER_FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ssdd_pkg::SAMPLE_W-1:0]      left_sample,
    input  logic [ssdd_pkg::SAMPLE_W-1:0]      right_sample,
    input  logic                               first_of_frame,
    input  logic                               last_of_frame,
    input  logic [ssdd_pkg::TIME_W-1:0]        time_us,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         direction,
    output logic [ssdd_pkg::BAL_W-1:0]         balance,
    output logic [ssdd_pkg::ENERGY_W-1:0]      energy,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [ssdd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int A_W = FILTER_FRAC_BITS + 17;
    localparam int Y_W = FILTER_FRAC_BITS + 18;
    localparam int P_W = A_W + ssdd_pkg::MUL_B_W;
    localparam int E_W = ssdd_pkg::ENERGY_W;
    localparam int D_W = E_W + ssdd_pkg::MUL_B_W;
    localparam logic [A_W-1:0] Y_LIM = A_W'(64'd65535 << FILTER_FRAC_BITS);

    // Configuration registers
    logic [ssdd_pkg::COOLDOWN_W-1:0] cooldown_reg;
    logic [E_W-1:0]                  energy_thr_reg;
    logic [ssdd_pkg::COEF_W-1:0]     bal_thr_reg;
    logic [ssdd_pkg::COEF_W-1:0]     alpha_reg;

    // Sequencer
    ssdd_pkg::state_t state_reg, state_next;

    // Per-channel filter state (index 0 left, 1 right)
    logic [ssdd_pkg::SAMPLE_W-1:0] x_reg   [2];
    logic [ssdd_pkg::SAMPLE_W-1:0] px_reg  [2];
    logic [Y_W-1:0]                py_reg  [2];
    logic [E_W-1:0]                sum_reg [2];
    logic                          neg_reg [2];

    // Frame state
    logic [ssdd_pkg::TIME_W-1:0] frame_time_reg;
    logic [ssdd_pkg::TIME_W-1:0] last_emit_reg;
    logic                        skipped_reg;
    logic                        last_reg;
    ssdd_pkg::dir_t              last_dir_reg;

    // Decision datapath
    logic [E_W-1:0]                  total_reg;
    logic [E_W-1:0]                  mag_reg;
    logic                            pos_reg;
    ssdd_pkg::dir_t                  dir_reg;
    logic [E_W-1:0]                  rem_reg;
    logic [ssdd_pkg::BAL_W-1:0]      q_reg;
    logic [ssdd_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    // Output register
    logic                            out_valid_reg;
    ssdd_pkg::dir_t                  out_dir_reg;
    logic [ssdd_pkg::BAL_W-1:0]      out_bal_reg;
    logic [E_W-1:0]                  out_energy_reg;

    // Combinational signals
    logic                            accept;
    logic [ssdd_pkg::TIME_W-1:0]     elapsed;
    logic                            skip_new;
    logic                            skip_now;
    logic [16:0]                     diff    [2];
    logic [Y_W:0]                    t_val   [2];
    logic [Y_W:0]                    t_abs   [2];
    logic                            t_neg   [2];
    logic [A_W-1:0]                  t_mag   [2];
    logic [A_W-1:0]                  ymag    [2];
    logic [A_W-1:0]                  ysat    [2];
    logic [Y_W-1:0]                  y_pos   [2];
    logic [Y_W-1:0]                  py_next [2];
    logic [ssdd_pkg::SAMPLE_W-1:0]   w_abs   [2];
    logic [E_W:0]                    s_ext   [2];
    logic [E_W-1:0]                  sum_next[2];
    logic [A_W-1:0]                  mul_a   [2];
    logic [ssdd_pkg::MUL_B_W-1:0]    mul_b   [2];
    logic                            mul_done[2];
    logic [P_W-1:0]                  mul_prod[2];
    logic                            mul_start;

    logic [E_W:0]                    tot_ext;
    logic [E_W-1:0]                  total_next;
    logic                            pos_next;
    logic [E_W-1:0]                  mag_next;
    logic                            below;
    logic                            dec_start;
    logic                            dec_done;
    logic [D_W-1:0]                  dec_prod;
    logic                            bal_gt;
    ssdd_pkg::dir_t                  dir_new;
    logic                            dir_same;
    logic                            total_zero;
    logic [E_W:0]                    trial;
    logic                            trial_ge;
    logic [E_W-1:0]                  rem_next;
    logic                            div_last;
    logic [ssdd_pkg::BAL_W-1:0]      bal_val;
    logic                            out_free;
    logic                            out_load;

    // Cooldown check on the incoming pair
    always_comb
    begin
        accept   = in_valid && in_ready;
        elapsed  = time_us - last_emit_reg;
        skip_new = elapsed < {{(ssdd_pkg::TIME_W - ssdd_pkg::COOLDOWN_W){1'b0}}, cooldown_reg};
        skip_now = first_of_frame ? skip_new : skipped_reg;
    end

    // Filter step and energy accumulate per channel
    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            diff[ch]  = {x_reg[ch][ssdd_pkg::SAMPLE_W-1], x_reg[ch]}
                      - {px_reg[ch][ssdd_pkg::SAMPLE_W-1], px_reg[ch]};
            t_val[ch] = {py_reg[ch][Y_W-1], py_reg[ch]}
                      + ({{(Y_W-16){diff[ch][16]}}, diff[ch]} << FILTER_FRAC_BITS);
            t_neg[ch] = t_val[ch][Y_W];
            t_abs[ch] = t_neg[ch] ? (~t_val[ch] + 1'b1) : t_val[ch];
            t_mag[ch] = t_abs[ch][A_W-1:0];

            ymag[ch]    = mul_prod[ch][P_W-1:ssdd_pkg::MUL_B_W];
            ysat[ch]    = (ymag[ch] > Y_LIM) ? Y_LIM : ymag[ch];
            y_pos[ch]   = {1'b0, ysat[ch]};
            py_next[ch] = neg_reg[ch] ? (~y_pos[ch] + 1'b1) : y_pos[ch];
            w_abs[ch]   = ysat[ch][FILTER_FRAC_BITS+15:FILTER_FRAC_BITS];

            s_ext[ch]    = {1'b0, sum_reg[ch]} + {{(E_W-31){1'b0}}, mul_prod[ch][31:0]};
            sum_next[ch] = s_ext[ch][E_W] ? '1 : s_ext[ch][E_W-1:0];

            mul_a[ch] = (state_reg == ssdd_pkg::ST_FILT) ? t_mag[ch]
                      : {{(A_W-16){1'b0}}, w_abs[ch]};
            mul_b[ch] = (state_reg == ssdd_pkg::ST_FILT) ? alpha_reg : w_abs[ch];
        end
    end

    // Two channel multipliers run in lockstep
    for (genvar g = 0; g < 2; g++)
    begin : g_chan
        ssdd_smul #(
            .A_W     (A_W)
        ) u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (mul_start),
            .a       (mul_a[g]),
            .b       (mul_b[g]),
            .done    (mul_done[g]),
            .product (mul_prod[g])
        );
    end

    // Balance threshold times total
    ssdd_smul #(
        .A_W     (E_W)
    ) u_dec_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dec_start),
        .a       (total_reg),
        .b       (bal_thr_reg),
        .done    (dec_done),
        .product (dec_prod)
    );

    // Frame decision and balance divider
    always_comb
    begin
        tot_ext    = {1'b0, sum_reg[0]} + {1'b0, sum_reg[1]};
        total_next = tot_ext[E_W] ? '1 : tot_ext[E_W-1:0];
        pos_next   = sum_reg[0] >= sum_reg[1];
        mag_next   = pos_next ? (sum_reg[0] - sum_reg[1]) : (sum_reg[1] - sum_reg[0]);
        below      = total_reg < energy_thr_reg;
        total_zero = (total_reg == '0);

        bal_gt  = ({mag_reg, {ssdd_pkg::MUL_B_W{1'b0}}} > dec_prod) && (mag_reg != '0);
        dir_new = bal_gt ? (pos_reg ? ssdd_pkg::DIR_LEFT : ssdd_pkg::DIR_RIGHT)
                         : ssdd_pkg::DIR_CENTRE;
        dir_same = (dir_new == last_dir_reg);

        trial    = (div_cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        trial_ge = trial >= {1'b0, total_reg};
        rem_next = trial_ge ? E_W'(trial - {1'b0, total_reg}) : trial[E_W-1:0];
        div_last = (div_cnt_reg == ssdd_pkg::DIV_CNT_W'(ssdd_pkg::DIV_STEPS - 1));

        if (pos_reg)
        begin
            bal_val = (q_reg > ssdd_pkg::BAL_POS_MAX) ? ssdd_pkg::BAL_POS_MAX : q_reg;
        end
        else
        begin
            bal_val = ~q_reg + 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssdd_pkg::ST_IDLE:
            begin
                if (in_valid && !skip_now)
                begin
                    state_next = ssdd_pkg::ST_FILT;
                end
            end
            ssdd_pkg::ST_FILT:
            begin
                state_next = ssdd_pkg::ST_MUL_ALPHA;
            end
            ssdd_pkg::ST_MUL_ALPHA:
            begin
                if (mul_done[0])
                begin
                    state_next = ssdd_pkg::ST_MUL_SQ;
                end
            end
            ssdd_pkg::ST_MUL_SQ:
            begin
                if (mul_done[0])
                begin
                    state_next = last_reg ? ssdd_pkg::ST_DEC_SUM : ssdd_pkg::ST_IDLE;
                end
            end
            ssdd_pkg::ST_DEC_SUM:
            begin
                state_next = ssdd_pkg::ST_DEC_GATE;
            end
            ssdd_pkg::ST_DEC_GATE:
            begin
                state_next = below ? ssdd_pkg::ST_IDLE : ssdd_pkg::ST_DEC_MUL;
            end
            ssdd_pkg::ST_DEC_MUL:
            begin
                if (dec_done)
                begin
                    if (dir_same)
                    begin
                        state_next = ssdd_pkg::ST_IDLE;
                    end
                    else if (total_zero)
                    begin
                        state_next = ssdd_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = ssdd_pkg::ST_DIV;
                    end
                end
            end
            ssdd_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ssdd_pkg::ST_EMIT;
                end
            end
            ssdd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ssdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == ssdd_pkg::ST_IDLE);
        mul_start = (state_reg == ssdd_pkg::ST_FILT)
                 || ((state_reg == ssdd_pkg::ST_MUL_ALPHA) && mul_done[0]);
        dec_start = (state_reg == ssdd_pkg::ST_DEC_GATE) && !below;
        out_free  = !out_valid_reg || out_ready;
        out_load  = (state_reg == ssdd_pkg::ST_EMIT) && out_free;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg   <= ssdd_pkg::COOLDOWN_RESET;
            energy_thr_reg <= ssdd_pkg::ENERGY_THR_RESET;
            bal_thr_reg    <= ssdd_pkg::BAL_THR_RESET;
            alpha_reg      <= ssdd_pkg::ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssdd_pkg::REG_COOLDOWN:    cooldown_reg   <= cfg_data[ssdd_pkg::COOLDOWN_W-1:0];
                ssdd_pkg::REG_ENERGY_THR:  energy_thr_reg <= cfg_data[E_W-1:0];
                ssdd_pkg::REG_BALANCE_THR: bal_thr_reg    <= cfg_data[ssdd_pkg::COEF_W-1:0];
                ssdd_pkg::REG_HP_ALPHA:    alpha_reg      <= cfg_data[ssdd_pkg::COEF_W-1:0];
                default:                   cooldown_reg   <= cooldown_reg;
            endcase
        end
    end

    // Advance sequencer and update filter, frame and output state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssdd_pkg::ST_IDLE;
            for (int ch = 0; ch < 2; ch++)
            begin
                px_reg[ch]  <= '0;
                py_reg[ch]  <= '0;
                sum_reg[ch] <= '0;
            end
            frame_time_reg <= '0;
            last_emit_reg  <= '0;
            skipped_reg    <= 1'b0;
            last_dir_reg   <= ssdd_pkg::DIR_CENTRE;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Start of frame: sample time, clear sums, decide skip
            if (accept && first_of_frame)
            begin
                frame_time_reg <= time_us;
                skipped_reg    <= skip_new;
                sum_reg[0]     <= '0;
                sum_reg[1]     <= '0;
            end

            // Filter output and previous input after the alpha multiply
            if ((state_reg == ssdd_pkg::ST_MUL_ALPHA) && mul_done[0])
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    px_reg[ch] <= x_reg[ch];
                    py_reg[ch] <= py_next[ch];
                end
            end

            // Accumulate squared outputs
            if ((state_reg == ssdd_pkg::ST_MUL_SQ) && mul_done[0])
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    sum_reg[ch] <= sum_next[ch];
                end
            end

            // Drop sums once the frame total is taken
            if (state_reg == ssdd_pkg::ST_DEC_SUM)
            begin
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
            end

            // Step the divider count
            if ((state_reg == ssdd_pkg::ST_DEC_MUL) && dec_done)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == ssdd_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            // Hand the result to the output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                last_emit_reg <= frame_time_reg;
                last_dir_reg  <= dir_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg[0] <= left_sample;
            x_reg[1] <= right_sample;
            last_reg <= last_of_frame;
        end

        if (state_reg == ssdd_pkg::ST_FILT)
        begin
            neg_reg[0] <= t_neg[0];
            neg_reg[1] <= t_neg[1];
        end

        if (state_reg == ssdd_pkg::ST_DEC_SUM)
        begin
            total_reg <= total_next;
            pos_reg   <= pos_next;
            mag_reg   <= mag_next;
        end

        if ((state_reg == ssdd_pkg::ST_DEC_MUL) && dec_done)
        begin
            dir_reg <= dir_new;
            rem_reg <= mag_reg;
            q_reg   <= '0;
        end
        else if (state_reg == ssdd_pkg::ST_DIV)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[ssdd_pkg::BAL_W-2:0], trial_ge};
        end

        if (out_load)
        begin
            out_dir_reg    <= dir_reg;
            out_bal_reg    <= bal_val;
            out_energy_reg <= total_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = out_dir_reg;
    assign balance   = out_bal_reg;
    assign energy    = out_energy_reg;

    // Channel multipliers must finish together
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done[0] == mul_done[1])
        else $error("channel multipliers out of step");

    // An emitted event always changes the direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> last_dir_reg != $past(last_dir_reg))
        else $error("event emitted without a direction change");

    // Balance quotient never exceeds one in Q1.15
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ssdd_pkg::ST_DIV) && div_last) |=> q_reg <= 16'h8000)
        else $error("balance quotient out of range");

    // A new pair is never taken while a multiply is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssdd_pkg::ST_IDLE) |-> !mul_done[0] && !dec_done)
        else $error("multiplier finished outside its step");

endmodule

[tb/stereo_sound_direction_detector_test.sv]
// Self-checking testbench for the stereo sound direction detector.
module stereo_sound_direction_detector_test;

    localparam int FRAC_BITS     = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 800;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASES        = 6;

    typedef longint unsigned u64_t;

    // One direction result as the block should report it
    typedef struct {
        ssdd_pkg::dir_t                    dir;
        logic [ssdd_pkg::BAL_W-1:0]        bal;
        logic [ssdd_pkg::ENERGY_W-1:0]     egy;
    } verdict_t;

    typedef enum int {
        FRAME_LEFT,
        FRAME_RIGHT,
        FRAME_BOTH,
        FRAME_QUIET
    } frame_kind_t;

    // Register values and idling for one random phase
    typedef struct {
        logic [ssdd_pkg::CFG_W-1:0] cooldown;
        logic [ssdd_pkg::CFG_W-1:0] energy_thr;
        logic [ssdd_pkg::CFG_W-1:0] bal_thr;
        logic [ssdd_pkg::CFG_W-1:0] alpha;
        int                         send_idle;
        int                         stall;
        int                         items;
    } phase_t;

    // Tracks filter state, predicts direction results and checks them
    class direction_scoreboard;
        localparam longint FILT_ONE  = longint'(1) << FRAC_BITS;
        localparam longint FILT_LIM  = 65535 * FILT_ONE;
        localparam u64_t   SUM_MAX   = 64'hFFFF_FFFF_FFFF;
        localparam u64_t   BAL_NEG_MAG = 64'd32768;

        logic [ssdd_pkg::COOLDOWN_W-1:0] cooldown   = ssdd_pkg::COOLDOWN_RESET;
        logic [ssdd_pkg::ENERGY_W-1:0]   energy_thr = ssdd_pkg::ENERGY_THR_RESET;
        logic [ssdd_pkg::COEF_W-1:0]     bal_thr    = ssdd_pkg::BAL_THR_RESET;
        logic [ssdd_pkg::COEF_W-1:0]     alpha      = ssdd_pkg::ALPHA_RESET;

        longint prev_in[2];
        longint prev_out[2];
        u64_t   ch_sum[2];
        logic [ssdd_pkg::TIME_W-1:0] last_emit   = '0;
        logic [ssdd_pkg::TIME_W-1:0] frame_stamp = '0;
        bit     frame_dropped;
        ssdd_pkg::dir_t last_dir = ssdd_pkg::DIR_CENTRE;

        verdict_t expected_q[$];
        int errors;
        int requests;
        int processed;
        int decisions;
        int dropped_frames;
        int results_checked;

        function void set_register(ssdd_pkg::reg_index_t idx,
                                   logic [ssdd_pkg::CFG_W-1:0] value);
            case (idx)
                ssdd_pkg::REG_COOLDOWN:    cooldown   = value[ssdd_pkg::COOLDOWN_W-1:0];
                ssdd_pkg::REG_ENERGY_THR:  energy_thr = value[ssdd_pkg::ENERGY_W-1:0];
                ssdd_pkg::REG_BALANCE_THR: bal_thr    = value[ssdd_pkg::COEF_W-1:0];
                ssdd_pkg::REG_HP_ALPHA:    alpha      = value[ssdd_pkg::COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function u64_t add_sat(u64_t a, u64_t b);
            u64_t s;
            s = a + b;
            return (s > SUM_MAX) ? SUM_MAX : s;
        endfunction

        // Advance one high-pass channel and return its squared integer output
        function u64_t filter_step(int ch, longint x);
            longint t;
            longint y;
            longint w;
            u64_t   m;
            bit     neg;
            t = prev_out[ch] + (x - prev_in[ch]) * FILT_ONE;
            neg = t < 0;
            m = neg ? u64_t'(-t) : u64_t'(t);
            y = longint'((m * alpha) >> ssdd_pkg::COEF_W);
            if (neg)
                y = -y;
            if (y > FILT_LIM)
                y = FILT_LIM;
            if (y < -FILT_LIM)
                y = -FILT_LIM;
            prev_in[ch] = x;
            prev_out[ch] = y;
            w = y / FILT_ONE;
            m = (w < 0) ? u64_t'(-w) : u64_t'(w);
            return m * m;
        endfunction

        // Note an accepted sample request and queue any result it causes
        function void note_request(logic [ssdd_pkg::SAMPLE_W-1:0] l,
                                   logic [ssdd_pkg::SAMPLE_W-1:0] r,
                                   bit first, bit last,
                                   logic [ssdd_pkg::TIME_W-1:0] stamp);
            u64_t total;
            u64_t mag;
            u64_t q;
            logic [ssdd_pkg::TIME_W-1:0] since;
            bit   pos;
            ssdd_pkg::dir_t dir;
            logic [ssdd_pkg::BAL_W-1:0] bal;
            requests++;
            // Check the cooldown on a frame's first pair
            if (first)
            begin
                frame_stamp = stamp;
                ch_sum[0] = 0;
                ch_sum[1] = 0;
                since = stamp - last_emit;
                frame_dropped = since < {{(ssdd_pkg::TIME_W-ssdd_pkg::COOLDOWN_W){1'b0}},
                                         cooldown};
                if (frame_dropped)
                    dropped_frames++;
            end
            if (frame_dropped)
                return;
            processed++;
            ch_sum[0] = add_sat(ch_sum[0], filter_step(0, longint'($signed(l))));
            ch_sum[1] = add_sat(ch_sum[1], filter_step(1, longint'($signed(r))));
            if (!last)
                return;

            // Decide the frame and clear the sums
            decisions++;
            total = add_sat(ch_sum[0], ch_sum[1]);
            pos = ch_sum[0] >= ch_sum[1];
            mag = pos ? ch_sum[0] - ch_sum[1] : ch_sum[1] - ch_sum[0];
            ch_sum[0] = 0;
            ch_sum[1] = 0;
            if (total < energy_thr)
                return;
            dir = ssdd_pkg::DIR_CENTRE;
            if (mag != 0 && (mag << ssdd_pkg::COEF_W) > (64'(bal_thr) * total))
                dir = pos ? ssdd_pkg::DIR_LEFT : ssdd_pkg::DIR_RIGHT;
            if (dir == last_dir)
                return;

            // Balance in Q1.15, truncated toward zero and saturated
            if (total == 0)
            begin
                bal = '0;
            end
            else
            begin
                q = (mag << (ssdd_pkg::BAL_W - 1)) / total;
                if (pos && q > 64'(ssdd_pkg::BAL_POS_MAX))
                    q = 64'(ssdd_pkg::BAL_POS_MAX);
                if (q > BAL_NEG_MAG)
                    q = BAL_NEG_MAG;
                bal = pos ? q[ssdd_pkg::BAL_W-1:0] : ssdd_pkg::BAL_W'(-q);
            end
            expected_q.push_back('{dir, bal, total[ssdd_pkg::ENERGY_W-1:0]});
            last_emit = frame_stamp;
            last_dir = dir;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        // Compare a delivered result with the oldest prediction
        task check_result(logic [1:0] dir, logic [ssdd_pkg::BAL_W-1:0] bal,
                          logic [ssdd_pkg::ENERGY_W-1:0] egy);
            verdict_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result dir=%0d balance=%0d energy=%0d",
                                          dir, $signed(bal), egy));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (dir !== want.dir)
                report_mismatch($sformatf("result %0d direction %0d, want %0d",
                                          results_checked, dir, want.dir));
            if (bal !== want.bal)
                report_mismatch($sformatf("result %0d balance %0d, want %0d",
                                          results_checked, $signed(bal), $signed(want.bal)));
            if (egy !== want.egy)
                report_mismatch($sformatf("result %0d energy %0d, want %0d",
                                          results_checked, egy, want.egy));
        endtask

        task flush_leftovers();
            verdict_t want;
            while (expected_q.size() != 0)
            begin
                want = expected_q.pop_front();
                report_mismatch($sformatf("missing result dir=%0d balance=%0d energy=%0d",
                                          want.dir, $signed(want.bal), want.egy));
            end
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [ssdd_pkg::SAMPLE_W-1:0]   left_sample = '0;
    logic [ssdd_pkg::SAMPLE_W-1:0]   right_sample = '0;
    logic                            first_of_frame = 1'b0;
    logic                            last_of_frame = 1'b0;
    logic [ssdd_pkg::TIME_W-1:0]     time_us = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      direction;
    logic [ssdd_pkg::BAL_W-1:0]      balance;
    logic [ssdd_pkg::ENERGY_W-1:0]   energy;
    logic                            cfg_write = 1'b0;
    logic [1:0]                      cfg_index = '0;
    logic [ssdd_pkg::CFG_W-1:0]      cfg_data = '0;

    direction_scoreboard sb = new;

    logic [ssdd_pkg::TIME_W-1:0] now_us = '0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    int  settings_applied = 0;
    bit  pressure_armed = 1'b0;

    stereo_sound_direction_detector #(
        .FILTER_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .direction      (direction),
        .balance        (balance),
        .energy         (energy),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    // Count down one long receiver hold once armed
    initial
    begin
        wait (pressure_armed);
        hold_left = HOLD_CYCLES;
        while (hold_left > 0)
        begin
            @(posedge clk);
            hold_left--;
        end
    end

    // Receive results, stalling at random or during the long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(direction, balance, energy);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [ssdd_pkg::SAMPLE_W-1:0] faint_sample();
        return ssdd_pkg::SAMPLE_W'($urandom_range(0, 400) - 200);
    endfunction

    function automatic logic [ssdd_pkg::TIME_W-1:0] any_time();
        return ssdd_pkg::TIME_W'({$urandom, $urandom});
    endfunction

    task automatic write_reg(ssdd_pkg::reg_index_t idx, logic [ssdd_pkg::CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Write every register; call only while the block is idle
    task automatic apply_config(logic [ssdd_pkg::CFG_W-1:0] cd, logic [ssdd_pkg::CFG_W-1:0] et,
                                logic [ssdd_pkg::CFG_W-1:0] bt, logic [ssdd_pkg::CFG_W-1:0] al);
        write_reg(ssdd_pkg::REG_COOLDOWN, cd);
        write_reg(ssdd_pkg::REG_ENERGY_THR, et);
        write_reg(ssdd_pkg::REG_BALANCE_THR, bt);
        write_reg(ssdd_pkg::REG_HP_ALPHA, al);
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    // Offer one sample request and hold it until accepted
    task automatic send_pair(logic [ssdd_pkg::SAMPLE_W-1:0] l, logic [ssdd_pkg::SAMPLE_W-1:0] r,
                             bit first, bit last, logic [ssdd_pkg::TIME_W-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        first_of_frame <= first;
        last_of_frame <= last;
        time_us <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(l, r, first, last, stamp);
    endtask

    // Send one frame of the given character, optionally without its marks
    task automatic send_frame(frame_kind_t kind, int len, bit no_first, bit no_last);
        logic [ssdd_pkg::SAMPLE_W-1:0] l;
        logic [ssdd_pkg::SAMPLE_W-1:0] r;
        logic [ssdd_pkg::TIME_W-1:0]   stamp;
        for (int i = 0; i < len; i++)
        begin
            // Advance the clock inside or just past the cooldown, or jump to any time
            if (i == 0)
            begin
                case ($urandom_range(0, 9))
                    0: now_us += ssdd_pkg::TIME_W'($urandom_range(0, sb.cooldown));
                    1: now_us = any_time();
                    default: now_us += ssdd_pkg::TIME_W'(sb.cooldown)
                                     + ssdd_pkg::TIME_W'($urandom_range(0, 5000));
                endcase
                stamp = now_us;
            end
            else
            begin
                stamp = any_time();
            end
            case (kind)
                FRAME_LEFT:
                begin
                    l = ssdd_pkg::SAMPLE_W'($urandom);
                    r = $urandom_range(0, 1) ? '0 : faint_sample();
                end
                FRAME_RIGHT:
                begin
                    l = $urandom_range(0, 1) ? '0 : faint_sample();
                    r = ssdd_pkg::SAMPLE_W'($urandom);
                end
                FRAME_BOTH:
                begin
                    l = ssdd_pkg::SAMPLE_W'($urandom);
                    r = ssdd_pkg::SAMPLE_W'($urandom);
                end
                default:
                begin
                    l = faint_sample();
                    r = faint_sample();
                end
            endcase
            send_pair(l, r, i == 0 && !no_first, i == len - 1 && !no_last, stamp);
        end
    endtask

    // Drop valid, drain expected results and let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        phase_t plan [PHASES];
        phase_t cur;
        int start;
        int pick;
        int len;

        plan = '{
            '{48'd0, 48'd0, 48'd0, 48'd65535, 0, 0, 130},
            '{48'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd65535, 48'd1, 74, 0, 40},
            '{48'd500000, 48'd1000000, 48'd19661, 48'd58600, 74, 0, 150},
            '{48'd1000, 48'd5000, 48'd30000, 48'd40000, 0, 74, 150},
            '{48'hFF_FFFF, 48'd0, 48'd65535, 48'd16384, 7, 7, 130},
            '{48'd0, 48'd0, 48'd0, 48'd0, 7, 7, 200}
        };

        // Hold reset, then release it
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Frame dropped while still inside the cooldown after reset
        send_pair(16'h7FFF, 16'h8000, 1'b1, 1'b0, 48'd0);
        send_pair(16'h8000, 16'h7FFF, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF);
        // Loud left frame at full-scale samples
        send_pair(16'h7FFF, 16'h0000, 1'b1, 1'b0, 48'd600000);
        send_pair(16'h8000, 16'h0001, 1'b0, 1'b0, 48'd0);
        send_pair(16'h7FFF, 16'hFFFF, 1'b0, 1'b1, 48'd0);
        // Right frame inside the cooldown, then a stray pair without a first mark
        send_pair(16'h0000, 16'h8000, 1'b1, 1'b0, 48'd700000);
        send_pair(16'h0001, 16'h7FFF, 1'b0, 1'b1, 48'd0);
        send_pair(16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 48'd0);
        // Loud right frame
        send_pair(16'h0000, 16'h8000, 1'b1, 1'b0, 48'd1200000);
        send_pair(16'h0000, 16'h7FFF, 1'b0, 1'b1, 48'd0);
        // Balanced frame whose tail lost its first mark
        send_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 48'd1800000);
        send_pair(16'h8000, 16'h8000, 1'b0, 1'b0, 48'd0);
        send_pair(16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 48'd0);
        // Near-silent frame below the energy gate
        send_pair(16'h0001, 16'hFFFF, 1'b1, 1'b0, 48'd2400000);
        send_pair(16'h0000, 16'h0000, 1'b0, 1'b1, 48'd0);
        // Single-pair frames across the timestamp wrap
        send_pair(16'h8000, 16'h0000, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF0);
        send_pair(16'h7FFF, 16'h0000, 1'b1, 1'b1, 48'd100);
        settle();

        // Zero alpha and zero gate give an all-zero frame total
        apply_config(48'd0, 48'd0, 48'd0, 48'd0);
        send_pair(16'h7FFF, 16'h8000, 1'b1, 1'b1, 48'd5);
        send_pair(16'h1234, 16'hEDCB, 1'b1, 1'b1, 48'd9);
        settle();

        // Random phases over several register settings and idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            cur = plan[p];
            if (p == PHASES - 1)
            begin
                cur.cooldown = ssdd_pkg::CFG_W'($urandom_range(0, 2000000));
                cur.energy_thr = ssdd_pkg::CFG_W'($urandom_range(0, 5000000));
                cur.bal_thr = ssdd_pkg::CFG_W'($urandom_range(0, 65535));
                cur.alpha = ssdd_pkg::CFG_W'($urandom_range(20000, 65535));
            end
            apply_config(cur.cooldown, cur.energy_thr, cur.bal_thr, cur.alpha);
            send_idle_pct = cur.send_idle;
            stall_pct = cur.stall;
            if (p == PHASES - 1)
                pressure_armed = 1'b1;
            start = sb.processed;
            while (sb.processed - start < cur.items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_pair(ssdd_pkg::SAMPLE_W'($urandom), ssdd_pkg::SAMPLE_W'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              any_time());
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
                    send_frame(frame_kind_t'($urandom_range(0, 3)), len,
                               pick < 12, pick >= 12 && pick < 16);
                end
            end
            settle();
        end

        sb.flush_leftovers();
        $display("Covered %0d sample requests (%0d filtered), %0d frames decided, %0d dropped",
                 sb.requests, sb.processed, sb.decisions, sb.dropped_frames);
        $display("Checked %0d direction results over %0d register settings, %0d mismatches",
                 sb.results_checked, settings_applied, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
